// ----- src/assert_macros.svh -----
// assertion macros shared by the servo pulse generator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// check on every edge out of reset
`define ASSERT_DIS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
// check on every edge, reset included
`define ASSERT_ALW(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_DIS(lbl, clk, rst_n, prop)
`define ASSERT_ALW(lbl, clk, prop)
`endif
`endif

// ----- src/msp_pkg.sv -----
// types and constants of the servo pulse generator
package msp_pkg;

	// command codes
	localparam logic [1:0] CMD_TICK    = 2'd0;
	localparam logic [1:0] CMD_SET     = 2'd1;
	localparam logic [1:0] CMD_DISABLE = 2'd2;

	// register indexes
	localparam logic [1:0] REG_PULSE_START  = 2'd0;
	localparam logic [1:0] REG_PULSE_END    = 2'd1;
	localparam logic [1:0] REG_FRAME_PERIOD = 2'd2;

	// register reset values
	localparam logic [15:0] PULSE_START_RST  = 16'd1000;
	localparam logic [15:0] PULSE_END_RST    = 16'd2000;
	localparam logic [15:0] FRAME_PERIOD_RST = 16'd20000;

	// percent value that turns a channel off
	localparam logic [7:0] VALUE_OFF = 8'd255;

	// floor division by 100: bias makes the product non-negative,
	// reciprocal ceil(2^32/100) is exact for dividends below 2^30
	localparam logic signed [25:0] DIV_BIAS   = 26'sd16711500;
	localparam logic signed [19:0] BIAS_QUOT  = 20'sd167115;
	localparam logic [25:0]        RECIP_100  = 26'd42949673;

	// one input word
	typedef struct packed {
		logic [1:0] command;
		logic [7:0] channel;
		logic [7:0] value;
	} msp_item_t;

	// one command ready to be applied to the frame state
	typedef struct packed {
		logic [1:0]  command;
		logic [7:0]  channel;
		logic [15:0] width;
	} msp_op_t;

endpackage

// ----- src/multichannel_servo_pulse_generator.sv -----
// top level of the multichannel servo pulse generator
//
//  channel | signals                          | direction | payload
//  in      | in_valid, in_stall               | word in   | command, channel, value
//  out     | out_valid, out_stall             | word out  | pulse_levels
//  cfg     | cfg_valid, cfg_ready             | write in  | cfg_index, cfg_data
//
// one word per cycle while the pipe is not held
// the width path runs through the input register, percent multiply,
// reciprocal divide, then clamp and state update into the result register
// the whole pipe holds while a result waits with out_stall high
// reset clears valids and frame state and loads the config reset values; cfg_ready is always high
`include "assert_macros.svh"
module multichannel_servo_pulse_generator #(
	parameter int NUM_CHANNELS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [7:0]  channel,
	input  logic [7:0]  value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  pulse_levels,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic               adv;
	logic               valid_s1;
	logic               valid_s2;
	logic               valid_s3;
	logic               out_valid_q;
	logic [7:0]         levels_q;
	logic [15:0]        pulse_start_q;
	logic [15:0]        pulse_end_q;
	logic [15:0]        frame_period_q;
	logic [7:0]         levels_next;
	msp_pkg::msp_item_t item_s1;
	msp_pkg::msp_op_t   op_s3;

	// pipe moves unless a result is held
	assign adv       = !(out_valid_q && out_stall);
	assign in_stall  = !adv;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_start_q  <= msp_pkg::PULSE_START_RST;
			pulse_end_q    <= msp_pkg::PULSE_END_RST;
			frame_period_q <= msp_pkg::FRAME_PERIOD_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				msp_pkg::REG_PULSE_START:  pulse_start_q  <= cfg_data;
				msp_pkg::REG_PULSE_END:    pulse_end_q    <= cfg_data;
				msp_pkg::REG_FRAME_PERIOD: frame_period_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// pipeline valids and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= in_valid;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1.command <= command;
			item_s1.channel <= channel;
			item_s1.value   <= value;
		end
	end

	msp_width_calc u_width (
		.clk         (clk),
		.en          (adv),
		.item_s1     (item_s1),
		.pulse_start (pulse_start_q),
		.pulse_end   (pulse_end_q),
		.op_s3       (op_s3)
	);

	msp_frame #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_frame (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (adv && valid_s3),
		.op           (op_s3),
		.frame_period (frame_period_q),
		.levels_next  (levels_next)
	);

	// result register
	always_ff @(posedge clk) begin
		if (adv && valid_s3) begin
			levels_q <= levels_next;
		end
	end

	assign out_valid    = out_valid_q;
	assign pulse_levels = levels_q;

	`ASSERT_ALW(a_reset_empty, clk, !arst_n |-> (!out_valid && !in_stall))
	`ASSERT_DIS(a_stall_needs_word, clk, arst_n, in_stall |-> out_valid)
	`ASSERT_DIS(a_word_from_pipe, clk, arst_n, $rose(out_valid) |-> $past(valid_s3))

endmodule

// ----- src/msp_width_calc.sv -----
// percent to pulse width datapath: multiply, reciprocal divide, clamp
module msp_width_calc (
	input  logic                clk,
	input  logic                en,
	input  msp_pkg::msp_item_t  item_s1,
	input  logic [15:0]         pulse_start,
	input  logic [15:0]         pulse_end,
	output msp_pkg::msp_op_t    op_s3
);

	logic signed [16:0] diff;
	logic signed [25:0] num;
	logic signed [25:0] num_s2;
	logic signed [25:0] biased;
	logic [50:0]        prod;
	logic [18:0]        quot_s3;
	logic signed [19:0] total;
	logic [15:0]        width;
	msp_pkg::msp_item_t item_s2;
	msp_pkg::msp_item_t item_s3;

	// signed span times percent
	assign diff = $signed({1'b0, pulse_end}) - $signed({1'b0, pulse_start});
	assign num  = 26'($signed({1'b0, item_s1.value}) * diff);

	always_ff @(posedge clk) begin
		if (en) begin
			num_s2  <= num;
			item_s2 <= item_s1;
		end
	end

	// biased floor divide by 100 through the reciprocal
	assign biased = num_s2 + msp_pkg::DIV_BIAS;
	assign prod   = biased[24:0] * msp_pkg::RECIP_100;

	always_ff @(posedge clk) begin
		if (en) begin
			quot_s3 <= prod[50:32];
			item_s3 <= item_s2;
		end
	end

	// add start, remove bias, saturate to 16 bits; value off gives width zero
	assign total = $signed({4'b0, pulse_start}) + $signed({1'b0, quot_s3})
		- msp_pkg::BIAS_QUOT;

	always_comb begin
		if (item_s3.value == msp_pkg::VALUE_OFF) begin
			width = 16'd0;
		end else if (total < 0) begin
			width = 16'd0;
		end else if (total > 20'sd65535) begin
			width = 16'hffff;
		end else begin
			width = total[15:0];
		end
	end

	assign op_s3.command = item_s3.command;
	assign op_s3.channel = item_s3.channel;
	assign op_s3.width   = width;

endmodule

// ----- src/msp_frame.sv -----
// frame counter, channel widths and output levels
`include "assert_macros.svh"
module msp_frame #(
	parameter int NUM_CHANNELS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  msp_pkg::msp_op_t  op,
	input  logic [15:0]       frame_period,
	output logic [7:0]        levels_next
);

	logic [15:0]                         cnt_q;
	logic [NUM_CHANNELS-1:0][15:0]       pend_q;
	logic [NUM_CHANNELS-1:0][15:0]       act_q;
	logic [NUM_CHANNELS-1:0]             lv_q;
	logic [15:0]                         cnt_n;
	logic [NUM_CHANNELS-1:0][15:0]       pend_n;
	logic [NUM_CHANNELS-1:0][15:0]       act_n;
	logic [NUM_CHANNELS-1:0]             lv_n;
	logic [NUM_CHANNELS+7:0]             lv_ext;
	logic                                wrap;
	logic                                tick_en;

	// frame restarts once the counter has reached the period
	assign wrap    = (cnt_q >= frame_period);
	assign tick_en = en && (op.command == msp_pkg::CMD_TICK);

	// apply one command to the frame state
	always_comb begin
		logic [15:0] cnt_v;
		cnt_v  = cnt_q;
		cnt_n  = cnt_q;
		pend_n = pend_q;
		act_n  = act_q;
		lv_n   = lv_q;
		case (op.command) inside
			msp_pkg::CMD_TICK: begin
				if (wrap) begin
					cnt_v = 16'd0;
					act_n = pend_q;
					for (int i = 0; i < NUM_CHANNELS; i++) begin
						if (pend_q[i] != 16'd0) lv_n[i] = 1'b1;
					end
				end
				for (int i = 0; i < NUM_CHANNELS; i++) begin
					if (act_n[i] != 16'd0 && act_n[i] == cnt_v) lv_n[i] = 1'b0;
				end
				cnt_n = cnt_v + 16'd1;
			end
			msp_pkg::CMD_SET, msp_pkg::CMD_DISABLE: begin
				for (int i = 0; i < NUM_CHANNELS; i++) begin
					if (op.channel == 8'(i)) begin
						pend_n[i] = (op.command == msp_pkg::CMD_SET) ? op.width : 16'd0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= msp_pkg::FRAME_PERIOD_RST;
			pend_q <= '0;
			act_q  <= '0;
			lv_q   <= '0;
		end else if (en) begin
			cnt_q  <= cnt_n;
			pend_q <= pend_n;
			act_q  <= act_n;
			lv_q   <= lv_n;
		end
	end

	// only channels 0..7 are visible
	assign lv_ext      = {8'b0, lv_n};
	assign levels_next = lv_ext[7:0];

	`ASSERT_DIS(a_tick_keeps_pending, clk, arst_n, tick_en |=> $stable(pend_q))
	`ASSERT_DIS(a_wrap_restarts, clk, arst_n, (tick_en && wrap) |=> cnt_q == 16'd1)
	`ASSERT_DIS(a_idle_holds_counter, clk, arst_n, !en |=> $stable(cnt_q))

endmodule

// ----- verif/multichannel_servo_pulse_generator_tb.sv -----
// self-checking testbench of the multichannel servo pulse generator
module multichannel_servo_pulse_generator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_CH = 8;
	localparam int LIMIT = 400000;
	localparam int RANDOM_PHASES = 8;
	localparam int WORDS_PER_PHASE = 116;
	localparam int HOLD_AT = 400;
	localparam int HOLD_CYCLES = 150;
	localparam int REPORT_MAX = 10;
	// codes the package leaves unnamed
	localparam logic [1:0] CMD_NONE = 2'd3;
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int PERCENT_FULL = 100;

	// one row of the directed part: a word, or a register write when is_cfg is set
	typedef struct packed {
		logic        is_cfg;
		logic [1:0]  code;
		logic [7:0]  chan;
		logic [15:0] data;
		logic        typed;
		logic [7:0]  levels;
	} row_t;

	localparam int NUM_ROWS = 35;
	row_t rows [NUM_ROWS] = '{
		// after reset: the first tick reloads an empty frame, nothing goes high
		'{1'b0, msp_pkg::CMD_TICK,    8'd0,   16'd0,   1'b1, 8'h00},
		'{1'b0, msp_pkg::CMD_SET,     8'd0,   16'd0,   1'b1, 8'h00},
		'{1'b0, msp_pkg::CMD_SET,     8'd7,   16'd100, 1'b1, 8'h00},
		// value off disables
		'{1'b0, msp_pkg::CMD_SET,     8'd1,   16'd255, 1'b1, 8'h00},
		// channels out of range are ignored
		'{1'b0, msp_pkg::CMD_SET,     8'd8,   16'd50,  1'b1, 8'h00},
		'{1'b0, msp_pkg::CMD_SET,     8'd255, 16'd254, 1'b1, 8'h00},
		'{1'b0, msp_pkg::CMD_DISABLE, 8'd2,   16'd0,   1'b1, 8'h00},
		// unused command reports the levels only
		'{1'b0, CMD_NONE,             8'd255, 16'd255, 1'b1, 8'h00},
		'{1'b1, msp_pkg::REG_PULSE_START,  8'd0, 16'd1,      1'b0, 8'h00},
		'{1'b1, msp_pkg::REG_PULSE_END,    8'd0, 16'd4,      1'b0, 8'h00},
		'{1'b1, msp_pkg::REG_FRAME_PERIOD, 8'd0, 16'd3,      1'b0, 8'h00},
		'{1'b1, REG_UNUSED,                8'd0, 16'hffff,   1'b0, 8'h00},
		// width above the period keeps the channel high
		'{1'b0, msp_pkg::CMD_SET,     8'd3,   16'd254, 1'b0, 8'h00},
		'{1'b0, msp_pkg::CMD_SET,     8'd4,   16'd33,  1'b0, 8'h00},
		'{1'b0, msp_pkg::CMD_SET,     8'd1,   16'd100, 1'b0, 8'h00},
		'{1'b0, msp_pkg::CMD_TICK,    8'd0,   16'd0,   1'b0, 8'h00},
		'{1'b0, msp_pkg::CMD_TICK,    8'd0,   16'd0,   1'b0, 8'h00},
		'{1'b0, msp_pkg::CMD_TICK,    8'd0,   16'd0,   1'b0, 8'h00},
		'{1'b0, msp_pkg::CMD_TICK,    8'd0,   16'd0,   1'b0, 8'h00},
		'{1'b0, msp_pkg::CMD_TICK,    8'd0,   16'd0,   1'b0, 8'h00},
		'{1'b0, msp_pkg::CMD_TICK,    8'd0,   16'd0,   1'b0, 8'h00},
		// end below start, period zero restarts the frame on every tick
		'{1'b1, msp_pkg::REG_PULSE_START,  8'd0, 16'd50,     1'b0, 8'h00},
		'{1'b1, msp_pkg::REG_PULSE_END,    8'd0, 16'd2,      1'b0, 8'h00},
		'{1'b1, msp_pkg::REG_FRAME_PERIOD, 8'd0, 16'd0,      1'b0, 8'h00},
		'{1'b0, msp_pkg::CMD_SET,     8'd5,   16'd100, 1'b0, 8'h00},
		'{1'b0, msp_pkg::CMD_SET,     8'd6,   16'd254, 1'b0, 8'h00},
		'{1'b0, msp_pkg::CMD_TICK,    8'd0,   16'd0,   1'b0, 8'h00},
		'{1'b0, msp_pkg::CMD_TICK,    8'd0,   16'd0,   1'b0, 8'h00},
		'{1'b0, msp_pkg::CMD_TICK,    8'd0,   16'd0,   1'b0, 8'h00},
		// value above 100 saturates the width high
		'{1'b1, msp_pkg::REG_PULSE_START,  8'd0, 16'd60000,  1'b0, 8'h00},
		'{1'b1, msp_pkg::REG_PULSE_END,    8'd0, 16'd65535,  1'b0, 8'h00},
		'{1'b1, msp_pkg::REG_FRAME_PERIOD, 8'd0, 16'd65535,  1'b0, 8'h00},
		'{1'b0, msp_pkg::CMD_SET,     8'd2,   16'd254, 1'b0, 8'h00},
		'{1'b0, msp_pkg::CMD_DISABLE, 8'd7,   16'd0,   1'b0, 8'h00},
		'{1'b0, msp_pkg::CMD_TICK,    8'd0,   16'd0,   1'b0, 8'h00}
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  command;
	logic [7:0]  channel;
	logic [7:0]  value;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  pulse_levels;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	// predicted frame state and registers
	logic [15:0] start_q;
	logic [15:0] end_q;
	logic [15:0] period_q;
	logic [15:0] frame_count;
	logic [15:0] pend_width [NUM_CH];
	logic [15:0] act_width [NUM_CH];
	logic [7:0]  levels_q;

	logic [7:0] levels_due [$];
	int words_taken;
	int bad_results;
	int cycle_count;
	bit steady;

	multichannel_servo_pulse_generator #(
		.NUM_CHANNELS(NUM_CH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.channel(channel),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pulse_levels(pulse_levels),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// percent to pulse width, floor toward minus infinity, clamped to 16 bits
	function automatic logic [15:0] width_for_percent(input logic [7:0] pct);
		longint diff;
		longint prod;
		longint quot;
		longint total;
		diff = longint'(end_q) - longint'(start_q);
		prod = longint'(pct) * diff;
		quot = prod / PERCENT_FULL;
		if (prod < 0 && (prod % PERCENT_FULL) != 0) begin
			quot = quot - 1;
		end
		total = longint'(start_q) + quot;
		if (total < 0) begin
			total = 0;
		end
		if (total > 65535) begin
			total = 65535;
		end
		return total[15:0];
	endfunction

	// apply one word to the predicted state and return the levels it leaves
	function automatic logic [7:0] apply_word(input logic [1:0] cmd, input logic [7:0] ch,
			input logic [7:0] val);
		if (cmd == msp_pkg::CMD_TICK) begin
			if (frame_count >= period_q) begin
				frame_count = 16'd0;
				for (int i = 0; i < NUM_CH; i++) begin
					act_width[i] = pend_width[i];
					if (act_width[i] != 16'd0) begin
						levels_q[i] = 1'b1;
					end
				end
			end
			for (int i = 0; i < NUM_CH; i++) begin
				if (act_width[i] != 16'd0 && act_width[i] == frame_count) begin
					levels_q[i] = 1'b0;
				end
			end
			frame_count = frame_count + 16'd1;
		end else if (cmd == msp_pkg::CMD_SET) begin
			if (ch < NUM_CH) begin
				pend_width[ch] = (val == msp_pkg::VALUE_OFF) ? 16'd0 : width_for_percent(val);
			end
		end else if (cmd == msp_pkg::CMD_DISABLE) begin
			if (ch < NUM_CH) begin
				pend_width[ch] = 16'd0;
			end
		end
		return levels_q;
	endfunction

	// sender gap: mostly short, a few long, none in a steady phase
	function automatic int sender_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 50);
	endfunction

	// offer one word and predict its levels once it is taken
	task automatic send_word(input logic [1:0] cmd, input logic [7:0] ch, input logic [7:0] val,
			input logic typed, input logic [7:0] typed_levels);
		int gap;
		logic [7:0] lv;
		gap = sender_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		channel <= ch;
		value <= val;
		do @(posedge clk); while (in_stall);
		lv = apply_word(cmd, ch, val);
		levels_due.push_back(typed ? typed_levels : lv);
		words_taken++;
	endtask

	// stop offering and wait until every predicted word has come out
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (levels_due.size() != 0) @(posedge clk);
		repeat (8) @(negedge clk);
	endtask

	// register write, mirrored into the prediction when taken
	task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			msp_pkg::REG_PULSE_START: start_q = data;
			msp_pkg::REG_PULSE_END: end_q = data;
			msp_pkg::REG_FRAME_PERIOD: period_q = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// one random word, weighted toward sets and ticks that make pulses
	task automatic random_word();
		int r;
		logic [1:0] cmd;
		logic [7:0] ch;
		logic [7:0] val;
		r = $urandom_range(0, 99);
		ch = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, NUM_CH - 1))
			: 8'($urandom_range(0, 255));
		if (r < 70) begin
			val = 8'($urandom_range(0, PERCENT_FULL));
		end else if (r < 80) begin
			val = msp_pkg::VALUE_OFF;
		end else begin
			val = 8'($urandom_range(0, 255));
		end
		r = $urandom_range(0, 99);
		if (r < 62) begin
			cmd = msp_pkg::CMD_TICK;
		end else if (r < 84) begin
			cmd = msp_pkg::CMD_SET;
		end else if (r < 95) begin
			cmd = msp_pkg::CMD_DISABLE;
		end else begin
			cmd = CMD_NONE;
		end
		send_word(cmd, ch, val, 1'b0, 8'h00);
	endtask

	// result checker against the oldest prediction
	always @(posedge clk) begin
		logic [7:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (levels_due.size() == 0) begin
				if (bad_results < REPORT_MAX) begin
					$display("unexpected word: pulse_levels=%h", pulse_levels);
				end
				bad_results++;
			end else begin
				want = levels_due.pop_front();
				if (pulse_levels !== want) begin
					if (bad_results < REPORT_MAX) begin
						$display("pulse_levels mismatch: expected %h, got %h", want,
							pulse_levels);
					end
					bad_results++;
				end
			end
		end
	end

	// receiver stalls: short bursts, free stretches, and one long hold
	initial begin
		int run;
		int r;
		logic lvl;
		bit held;
		held = 0;
		out_stall = 1'b0;
		forever begin
			r = $urandom_range(0, 99);
			if (!held && words_taken >= HOLD_AT) begin
				held = 1;
				lvl = 1'b1;
				run = HOLD_CYCLES;
			end else if (r < 10) begin
				lvl = 1'b0;
				run = $urandom_range(30, 100);
			end else if (r < 60) begin
				lvl = 1'b0;
				run = $urandom_range(1, 4);
			end else if (r < 95) begin
				lvl = 1'b1;
				run = $urandom_range(1, 3);
			end else begin
				lvl = 1'b1;
				run = $urandom_range(10, 40);
			end
			repeat (run) begin
				@(negedge clk);
				out_stall <= lvl;
			end
		end
	end

	// watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("multichannel_servo_pulse_generator_tb NOT OK");
		$finish;
	end

	// reset, directed table, random phases, drain and verdict
	initial begin
		logic [15:0] per;
		in_valid = 1'b0;
		command = msp_pkg::CMD_TICK;
		channel = 8'd0;
		value = 8'd0;
		cfg_valid = 1'b0;
		cfg_index = msp_pkg::REG_PULSE_START;
		cfg_data = 16'd0;
		words_taken = 0;
		bad_results = 0;
		steady = 0;
		start_q = msp_pkg::PULSE_START_RST;
		end_q = msp_pkg::PULSE_END_RST;
		period_q = msp_pkg::FRAME_PERIOD_RST;
		frame_count = msp_pkg::FRAME_PERIOD_RST;
		levels_q = 8'h00;
		for (int i = 0; i < NUM_CH; i++) begin
			pend_width[i] = 16'd0;
			act_width[i] = 16'd0;
		end
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed rows
		for (int k = 0; k < NUM_ROWS; k++) begin
			if (rows[k].is_cfg) begin
				wait_idle();
				write_reg(rows[k].code, rows[k].data);
			end else begin
				send_word(rows[k].code, rows[k].chan, rows[k].data[7:0], rows[k].typed,
					rows[k].levels);
			end
		end

		// random phases, the first three at register extremes
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			wait_idle();
			steady = (p == 4);
			case (p)
				0: begin
					write_reg(msp_pkg::REG_PULSE_START, 16'd0);
					write_reg(msp_pkg::REG_PULSE_END, 16'hffff);
					write_reg(msp_pkg::REG_FRAME_PERIOD, 16'd0);
				end
				1: begin
					write_reg(msp_pkg::REG_PULSE_START, 16'hffff);
					write_reg(msp_pkg::REG_PULSE_END, 16'd0);
					write_reg(msp_pkg::REG_FRAME_PERIOD, 16'd1);
					write_reg(REG_UNUSED, 16'h5a5a);
				end
				2: begin
					write_reg(msp_pkg::REG_PULSE_START, 16'd0);
					write_reg(msp_pkg::REG_PULSE_END, 16'd0);
					write_reg(msp_pkg::REG_FRAME_PERIOD, 16'hffff);
				end
				default: begin
					per = 16'($urandom_range(1, 40));
					if ($urandom_range(0, 3) == 0) begin
						write_reg(msp_pkg::REG_PULSE_START, 16'($urandom_range(0, 65535)));
						write_reg(msp_pkg::REG_PULSE_END, 16'($urandom_range(0, 65535)));
					end else begin
						write_reg(msp_pkg::REG_PULSE_START, 16'($urandom_range(0, per)));
						write_reg(msp_pkg::REG_PULSE_END, 16'($urandom_range(0, per + 8)));
					end
					write_reg(msp_pkg::REG_FRAME_PERIOD, per);
				end
			endcase
			repeat (WORDS_PER_PHASE) random_word();
		end

		wait_idle();
		if (bad_results == 0) begin
			$display("multichannel_servo_pulse_generator_tb OK");
		end else begin
			$display("multichannel_servo_pulse_generator_tb NOT OK");
		end
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+src
src/msp_pkg.sv
src/msp_width_calc.sv
src/msp_frame.sv
src/multichannel_servo_pulse_generator.sv
verif/multichannel_servo_pulse_generator_tb.sv
